FILE: rtl/ostst_pkg.sv
// Package of the one-shot timer slot table: widths, operation and result codes.
package ostst_pkg;

  localparam int SlotCountDef = 32;
  localparam int SlotW        = 5;
  localparam int TimeW        = 64;
  localparam int RawW         = 32;
  localparam int InDataW      = 168;
  localparam int OutDataW     = 72;
  localparam int OpW          = 3;
  localparam int KindW        = 2;

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_SETUP      = 3'd1,
    OP_CANCEL     = 3'd2,
    OP_SET_UPTIME = 3'd3,
    OP_ADD_SKEW   = 3'd4
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_GRANTED = 2'd0,
    KIND_NO_FREE = 2'd1,
    KIND_EXPIRED = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SUM   = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_GRANT = 5'b10000
  } state_e;

endpackage

FILE: rtl/one_shot_timer_slot_table.sv
// One-shot timer slot table: millisecond uptime keeping and deadline slots in a memory.
//
// Input words arrive on the s_axis channel: tuser carries the operation (tick, setup,
// cancel, set uptime, add skew) and tdata the operands. Result words leave on m_axis:
// tuser carries the event kind, tdata the slot and the uptime, tlast marks the final
// word caused by one input word. One input word is taken at a time.
// Set uptime, add skew, cancel and unknown operations pass through SUM and give no word.
// Setup goes through GRANT and gives one word: the lowest free slot, or no free slot.
// A tick passes the SUM, SCAN and EMIT states: the deadlines sit in a synchronous
// memory with one write and one read port that is read one slot per cycle and compared
// with the new uptime; the expired slots are then reported in ascending order.
// The output register lets the last result word wait while the next input is taken.
// Reset clears the active map, the time base and the skew; the deadline memory is not
// cleared, since a slot is only ever compared once setup has written it.
// When the receiver stalls, the block holds its current word and waits.
module one_shot_timer_slot_table
  import ostst_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // raw_ms, delay_ms, slot_index, new_uptime, skew_delta, zero padding
  input  logic [InDataW-1:0]  s_axis_tdata,
  // operation
  input  logic [OpW-1:0]      s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // event_slot, uptime_now, zero padding
  output logic [OutDataW-1:0] m_axis_tdata,
  // event_kind
  output logic [KindW-1:0]    m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CntW = $clog2(SLOT_COUNT + 1);

  function automatic logic [IdxW-1:0] low_set(input logic [SLOT_COUNT-1:0] v);
    logic [IdxW-1:0] r;
    r = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IdxW'(i);
      end
    end
    return r;
  endfunction

  logic [RawW-1:0]   in_raw;
  logic [RawW-1:0]   in_delay;
  logic [SlotW-1:0]  in_slot;
  logic [TimeW-1:0]  in_uptime;
  logic [RawW-1:0]   in_skew;
  op_e               in_op;

  assign in_raw    = s_axis_tdata[31:0];
  assign in_delay  = s_axis_tdata[63:32];
  assign in_slot   = s_axis_tdata[68:64];
  assign in_uptime = s_axis_tdata[132:69];
  assign in_skew   = s_axis_tdata[164:133];
  assign in_op     = op_e'(s_axis_tuser);

  state_e            state_q, state_d;
  logic [TimeW-1:0]  ext_q, ext_d;
  logic [RawW-1:0]   last_raw_q, last_raw_d;
  logic [TimeW-1:0]  skew_q, skew_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [SLOT_COUNT-1:0] act_q, act_d;
  logic [SLOT_COUNT-1:0] due_q, due_d;
  logic [CntW-1:0]   scan_q, scan_d;
  logic              chk_vld_q, chk_vld_d;
  logic [IdxW-1:0]   chk_idx_q;
  logic [TimeW-1:0]  rd_q;
  logic              out_vld_q, out_vld_d;
  kind_e             out_kind_q, out_kind_d;
  logic [SlotW-1:0]  out_slot_q, out_slot_d;
  logic [TimeW-1:0]  out_time_q, out_time_d;
  logic              out_last_q, out_last_d;
  kind_e             gnt_kind_q, gnt_kind_d;
  logic [SlotW-1:0]  gnt_slot_q, gnt_slot_d;

  logic [TimeW-1:0]  dl_mem [SLOT_COUNT];
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [TimeW-1:0]  mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;

  logic              accept;
  logic              out_free;
  logic [IdxW-1:0]   free_idx;
  logic [IdxW-1:0]   due_idx;
  logic [RawW-1:0]   raw_diff;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign free_idx      = low_set(~act_q);
  assign due_idx       = low_set(due_q);
  assign raw_diff      = in_raw - last_raw_q;
  assign mem_raddr     = scan_q[IdxW-1:0];

  always_comb begin
    state_d    = state_q;
    ext_d      = ext_q;
    last_raw_d = last_raw_q;
    skew_d     = skew_q;
    now_d      = now_q;
    act_d      = act_q;
    due_d      = due_q;
    scan_d     = scan_q;
    chk_vld_d  = 1'b0;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_kind_d = out_kind_q;
    out_slot_d = out_slot_q;
    out_time_d = out_time_q;
    out_last_d = out_last_q;
    gnt_kind_d = gnt_kind_q;
    gnt_slot_d = gnt_slot_q;
    mem_we     = 1'b0;
    mem_waddr  = free_idx;
    mem_wdata  = now_q + TimeW'(in_delay);
    mem_re     = 1'b0;

    if (chk_vld_q && act_q[chk_idx_q] && (rd_q <= now_q)) begin
      due_d[chk_idx_q] = 1'b1;
      act_d[chk_idx_q] = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SUM;
          case (in_op)
            OP_TICK: begin
              if (in_raw < last_raw_q) begin
                ext_d = {ext_q[63:32] + 32'd1, in_raw};
              end else begin
                ext_d = ext_q + TimeW'(raw_diff);
              end
              last_raw_d = in_raw;
              due_d      = '0;
            end
            OP_SETUP: begin
              state_d = ST_GRANT;
              if (~&act_q) begin
                mem_we          = 1'b1;
                act_d[free_idx] = 1'b1;
                gnt_kind_d      = KIND_GRANTED;
                gnt_slot_d      = SlotW'(free_idx);
              end else begin
                gnt_kind_d = KIND_NO_FREE;
                gnt_slot_d = '0;
              end
            end
            OP_CANCEL: begin
              if (int'(in_slot) < SLOT_COUNT) begin
                act_d[in_slot[IdxW-1:0]] = 1'b0;
              end
            end
            OP_SET_UPTIME: begin
              ext_d      = in_uptime;
              last_raw_d = in_uptime[31:0];
              skew_d     = '0;
            end
            OP_ADD_SKEW: begin
              skew_d = skew_q + {{32{in_skew[31]}}, in_skew};
            end
            default: begin
              state_d = ST_SUM;
            end
          endcase
          if (in_op == OP_TICK) begin
            scan_d = '0;
          end
        end
      end
      ST_SUM: begin
        now_d   = ext_q + skew_q;
        state_d = (scan_q == '0) ? ST_SCAN : ST_IDLE;
        if (scan_q != '0) begin
          scan_d = CntW'(SLOT_COUNT);
        end
      end
      ST_SCAN: begin
        if (scan_q == CntW'(SLOT_COUNT)) begin
          state_d = ST_EMIT;
        end else begin
          mem_re    = 1'b1;
          chk_vld_d = 1'b1;
          scan_d    = scan_q + CntW'(1);
        end
      end
      ST_EMIT: begin
        if (due_q == '0) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d        = 1'b1;
          out_kind_d       = KIND_EXPIRED;
          out_slot_d       = SlotW'(due_idx);
          out_time_d       = now_q;
          out_last_d       = ((due_q & (due_q - SLOT_COUNT'(1))) == '0);
          due_d[due_idx]   = 1'b0;
        end
      end
      ST_GRANT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_kind_d = gnt_kind_q;
          out_slot_d = gnt_slot_q;
          out_time_d = now_q;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // SUM only enters the scan when the accepted word was a tick; other
  // operations park the scan counter at its end value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ext_q      <= '0;
      last_raw_q <= '0;
      skew_q     <= '0;
      now_q      <= '0;
      act_q      <= '0;
      due_q      <= '0;
      scan_q     <= CntW'(SLOT_COUNT);
      chk_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ext_q      <= ext_d;
      last_raw_q <= last_raw_d;
      skew_q     <= skew_d;
      now_q      <= now_d;
      act_q      <= act_d;
      due_q      <= due_d;
      scan_q     <= (state_q == ST_IDLE && accept && in_op != OP_TICK) ?
                    CntW'(1) : scan_d;
      chk_vld_q  <= chk_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= mem_raddr;
    out_kind_q <= out_kind_d;
    out_slot_q <= out_slot_d;
    out_time_q <= out_time_d;
    out_last_q <= out_last_d;
    gnt_kind_q <= gnt_kind_d;
    gnt_slot_q <= gnt_slot_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= dl_mem[mem_raddr];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_time_q, out_slot_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: rtl/ostst_checker.sv
// Port checker of the one-shot timer slot table and its bind statement.
module ostst_checker
  import ostst_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic [OpW-1:0]      s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [KindW-1:0]    m_axis_tuser,
  input logic                m_axis_tlast
);

  // A waiting result word stays until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  // Every input word occupies the block: no second word is taken straight after it.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second input word taken while one is in work");

  // Setup answers with a single word.
  a_grant_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != KIND_EXPIRED |-> m_axis_tlast)
    else $error("setup answer not marked as final word");

  // A full table reports slot zero.
  a_no_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_NO_FREE |-> m_axis_tdata[4:0] == '0)
    else $error("no free slot reported with a non-zero slot");

endmodule

bind one_shot_timer_slot_table ostst_checker u_ostst_checker (.*);

FILE: tb/tb_one_shot_timer_slot_table.sv
// Testbench of the one-shot timer slot table: directed and random words against a predictor.
`timescale 1ns / 100ps

module tb_one_shot_timer_slot_table;
  import ostst_pkg::*;

  localparam int SlotCount = SlotCountDef;
  localparam logic [OpW-1:0] OpMaxCode = '1;
  localparam int DrainCycles = 2 * SlotCount + 16;

  typedef struct {
    logic [OpW-1:0]   op;
    logic [RawW-1:0]  raw;
    logic [RawW-1:0]  delay;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] uptime;
    logic [RawW-1:0]  skew;
  } timer_cmd_t;

  typedef struct {
    kind_e            kind;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] uptime;
    logic             is_last;
  } timer_evt_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // raw_ms, delay_ms, slot_index, new_uptime, skew_delta, zero padding
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // operation
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // event_slot, uptime_now, zero padding
  logic [OutDataW-1:0] m_axis_tdata;
  // event_kind
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  int send_idle_pct = 37;
  int recv_idle_pct = 77;
  int mismatch_count = 0;

  // Predicted state of the slot table and its time base.
  logic             slot_busy [SlotCount];
  logic [TimeW-1:0] slot_deadline [SlotCount];
  logic [TimeW-1:0] ext_ms = '0;
  logic [RawW-1:0]  last_raw = '0;
  logic [TimeW-1:0] skew_sum = '0;

  timer_evt_t pending_events[$];

  one_shot_timer_slot_table #(
    .SLOT_COUNT(SlotCount)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < SlotCount; i++) begin
      slot_busy[i] = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void predict_timer_word(timer_cmd_t cmd);
    logic [TimeW-1:0] now;
    timer_evt_t       ev;
    int               last_due;
    int               free_slot;
    last_due  = -1;
    free_slot = -1;
    case (cmd.op)
      OP_TICK: begin
        if (cmd.raw < last_raw) begin
          ext_ms   = (ext_ms + (64'd1 << 32)) & ~64'hFFFF_FFFF;
          last_raw = '0;
        end
        ext_ms   = ext_ms + {32'd0, cmd.raw - last_raw};
        last_raw = cmd.raw;
        now      = ext_ms + skew_sum;
        for (int i = 0; i < SlotCount; i++) begin
          if (slot_busy[i] && slot_deadline[i] <= now) last_due = i;
        end
        for (int i = 0; i <= last_due; i++) begin
          if (slot_busy[i] && slot_deadline[i] <= now) begin
            slot_busy[i] = 1'b0;
            ev.kind      = KIND_EXPIRED;
            ev.slot      = i[SlotW-1:0];
            ev.uptime    = now;
            ev.is_last   = (i == last_due);
            pending_events.push_back(ev);
          end
        end
      end
      OP_SETUP: begin
        now = ext_ms + skew_sum;
        for (int i = SlotCount - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_slot = i;
        end
        ev.uptime  = now;
        ev.is_last = 1'b1;
        if (free_slot >= 0) begin
          slot_busy[free_slot]     = 1'b1;
          slot_deadline[free_slot] = now + {32'd0, cmd.delay};
          ev.kind = KIND_GRANTED;
          ev.slot = free_slot[SlotW-1:0];
        end else begin
          ev.kind = KIND_NO_FREE;
          ev.slot = '0;
        end
        pending_events.push_back(ev);
      end
      OP_CANCEL: begin
        if (int'(cmd.slot) < SlotCount) slot_busy[cmd.slot] = 1'b0;
      end
      OP_SET_UPTIME: begin
        ext_ms   = cmd.uptime;
        last_raw = cmd.uptime[RawW-1:0];
        skew_sum = '0;
      end
      OP_ADD_SKEW: begin
        skew_sum = skew_sum + {{32{cmd.skew[RawW-1]}}, cmd.skew};
      end
      default: begin
      end
    endcase
  endfunction

  function automatic timer_cmd_t random_cmd(logic [OpW-1:0] op);
    timer_cmd_t cmd;
    cmd.op     = op;
    cmd.raw    = $urandom;
    cmd.delay  = $urandom;
    cmd.slot   = SlotW'($urandom_range(SlotCount - 1));
    cmd.uptime = {$urandom, $urandom};
    cmd.skew   = $urandom;
    return cmd;
  endfunction

  task automatic send_word(input timer_cmd_t cmd);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd.op;
    s_axis_tdata  <= {3'b000, cmd.skew, cmd.uptime, cmd.slot, cmd.delay, cmd.raw};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_timer_word(cmd);
  endtask

  task automatic send_tick(logic [RawW-1:0] raw);
    timer_cmd_t cmd;
    cmd     = random_cmd(OP_TICK);
    cmd.raw = raw;
    send_word(cmd);
  endtask

  task automatic send_setup(logic [RawW-1:0] delay);
    timer_cmd_t cmd;
    cmd       = random_cmd(OP_SETUP);
    cmd.delay = delay;
    send_word(cmd);
  endtask

  task automatic send_cancel(logic [SlotW-1:0] slot);
    timer_cmd_t cmd;
    cmd      = random_cmd(OP_CANCEL);
    cmd.slot = slot;
    send_word(cmd);
  endtask

  task automatic send_set_uptime(logic [TimeW-1:0] uptime);
    timer_cmd_t cmd;
    cmd        = random_cmd(OP_SET_UPTIME);
    cmd.uptime = uptime;
    send_word(cmd);
  endtask

  task automatic send_add_skew(logic [RawW-1:0] skew);
    timer_cmd_t cmd;
    cmd      = random_cmd(OP_ADD_SKEW);
    cmd.skew = skew;
    send_word(cmd);
  endtask

  // A deadline of zero is due at once; a cancelled slot must never expire.
  task automatic test_basic_expiry();
    send_tick('0);
    send_setup('0);
    send_setup('1);
    send_tick('0);
    send_cancel(SlotW'(1));
    send_cancel('1);
  endtask

  // A raw value that goes backwards carries into the upper half of the uptime, past the next 2^32 boundary.
  task automatic test_raw_rollover();
    send_tick('1);
    send_setup(32'd1);
    send_tick('0);
  endtask

  task automatic test_skew_extremes();
    send_add_skew(32'h8000_0000);
    send_setup('0);
    send_add_skew(32'h7FFF_FFFF);
    send_tick('0);
  endtask

  // Deadline and uptime both wrap past 2^64.
  task automatic test_uptime_wrap();
    send_set_uptime(64'hFFFF_FFFF_FFFF_FFF0);
    send_setup(32'h20);
    send_tick(32'hFFFF_FFF1);
    send_add_skew(32'h20);
    send_setup('0);
    send_set_uptime('1);
    send_set_uptime('0);
  endtask

  task automatic test_ignored_ops();
    timer_cmd_t cmd;
    for (int c = int'(OP_ADD_SKEW) + 1; c <= int'(OpMaxCode); c++) begin
      cmd        = random_cmd(c[OpW-1:0]);
      cmd.raw    = '1;
      cmd.delay  = '1;
      cmd.slot   = '0;
      cmd.uptime = '1;
      cmd.skew   = '1;
      send_word(cmd);
    end
    send_setup(32'd5);
  endtask

  // Fills every slot, asks once more, then retires the whole table with one tick.
  task automatic test_table_full();
    for (int i = 0; i <= SlotCount; i++) begin
      send_setup($urandom_range(10));
    end
    send_tick(last_raw + 32'd1000);
  endtask

  task automatic test_random_traffic(int word_count, int snd_pct, int rcv_pct);
    timer_cmd_t cmd;
    int         counted;
    int         pick;
    int         start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    counted = 0;
    while (counted < word_count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        cmd = random_cmd(OpW'($urandom_range(int'(OpMaxCode))));
      end else if (pick < 45) begin
        cmd = random_cmd(OP_TICK);
        if ($urandom_range(19) != 0) cmd.raw = last_raw + $urandom_range(30);
      end else if (pick < 75) begin
        cmd = random_cmd(OP_SETUP);
        if ($urandom_range(19) != 0) cmd.delay = $urandom_range(100);
      end else if (pick < 88) begin
        cmd   = random_cmd(OP_CANCEL);
        start = $urandom_range(SlotCount - 1);
        if ($urandom_range(3) != 0) begin
          for (int i = 0; i < SlotCount; i++) begin
            if (slot_busy[(start + i) % SlotCount]) begin
              cmd.slot = SlotW'((start + i) % SlotCount);
              break;
            end
          end
        end
      end else if (pick < 95) begin
        cmd = random_cmd(OP_ADD_SKEW);
        if ($urandom_range(3) != 0) cmd.skew = $urandom_range(100) - 50;
      end else begin
        cmd = random_cmd(OP_SET_UPTIME);
        if ($urandom_range(1) != 0) begin
          cmd.uptime = ext_ms + skew_sum + $urandom_range(50);
        end
      end
      send_word(cmd);
      if (cmd.op <= OP_ADD_SKEW) counted++;
    end
  endtask

  always @(posedge clk_i) begin
    timer_evt_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result word: kind %0d, slot %0d", m_axis_tuser, m_axis_tdata[4:0]);
        mismatch_count++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[4:0] !== want.slot) begin
          $error("event_slot: expected %0d, got %0d", want.slot, m_axis_tdata[4:0]);
          mismatch_count++;
        end
        if (m_axis_tdata[68:5] !== want.uptime) begin
          $error("uptime_now: expected %h, got %h", want.uptime, m_axis_tdata[68:5]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.is_last) begin
          $error("last: expected %0d, got %0d", want.is_last, m_axis_tlast);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_basic_expiry();
    test_raw_rollover();
    test_skew_extremes();
    test_uptime_wrap();
    test_ignored_ops();
    test_table_full();
    test_random_traffic(57, 37, 77);
    test_random_traffic(57, 77, 37);
    test_random_traffic(56, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ostst_pkg.sv
rtl/one_shot_timer_slot_table.sv
rtl/ostst_checker.sv
tb/tb_one_shot_timer_slot_table.sv
